/* hdl/base64_frame_transmitter_macros.svh */
// Assertion macros shared by the base64 frame transmitter RTL.
`ifndef BASE64_FRAME_TRANSMITTER_MACROS_SVH
`define BASE64_FRAME_TRANSMITTER_MACROS_SVH

`ifndef SYNTH
`define B64FT_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`else
`define B64FT_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons)
`endif

`ifndef SYNTH
`define B64FT_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define B64FT_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif

`endif

/* hdl/b64ft_pkg.sv */
// Shared types, constants and functions of the base64 frame transmitter.
`default_nettype none

package b64ft_pkg;

  localparam int unsigned B64FT_FIFO_DEPTH = 4;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [15:0] START_OPCODE_RST = 16'd1545;
  localparam logic [15:0] CONT_OPCODE_RST  = 16'd1044;
  localparam logic [7:0]  MAX_FRAME_RST    = 8'd127;
  localparam logic [7:0]  MIN_BUDGET       = 8'd16;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [7:0]  CHAR_NL          = 8'h0A;
  localparam logic [7:0]  CHAR_PAD         = 8'h3D;

  typedef enum logic [1:0] {
    REG_START_OPCODE = 2'd0,
    REG_CONT_OPCODE  = 2'd1,
    REG_MAX_FRAME    = 2'd2
  } reg_idx_t;

  // Character slots of one command, sent in ascending order.
  localparam int unsigned POS_NL_A   = 0;
  localparam int unsigned POS_HDR_A  = 1;
  localparam int unsigned POS_GRP_A  = 3;
  localparam int unsigned POS_NL_B   = 7;
  localparam int unsigned POS_HDR_B  = 8;
  localparam int unsigned POS_GRP_B  = 10;
  localparam int unsigned POS_GRP_C  = 14;
  localparam int unsigned POS_NL_END = 18;
  localparam int unsigned NUM_POS    = 19;
  localparam int unsigned POS_W      = 5;

  typedef logic [NUM_POS-1:0] pos_mask_t;

  typedef struct packed {
    pos_mask_t   mask;
    logic        hdr_a_start;
    logic [23:0] grp_a;
    logic [23:0] grp_b;
    logic        b_pad;
    logic [7:0]  grp_c;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    priority if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [5:0] sextet(input logic [23:0] w, input logic [1:0] k);
    logic [5:0] s;
    unique case (k)
      2'd0: s = w[23:18];
      2'd1: s = w[17:12];
      2'd2: s = w[11:6];
      default: s = w[5:0];
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/b64ft_fifo.sv */
// Command queue between the classifier front and the character sequencer.
`default_nettype none
`include "base64_frame_transmitter_macros.svh"

module b64ft_fifo
  import b64ft_pkg::*;
#(
  parameter int unsigned DEPTH = B64FT_FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `B64FT_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full)
  `B64FT_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty)
  `B64FT_ASSERT_NEXT(a_push_kept, clk, rst, push && !pop, !empty)

endmodule

`default_nettype wire

/* hdl/b64ft_front.sv */
// Front end: accepts payload bytes, keeps CRC and framing state, queues commands.
`default_nettype none

module b64ft_front
  import b64ft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        packet_start,
  input  wire logic [15:0] packet_len,
  input  wire logic [7:0]  max_frame_chars,
  input  wire logic        fifo_full,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [15:0] crc_acc, crc_acc_next;
  logic [15:0] group_bytes, group_bytes_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [7:0]  frame_chars, frame_chars_next;
  logic [15:0] bytes_left, bytes_left_next;

  logic        accept;
  logic [7:0]  lim;
  logic [15:0] crc_new;
  logic        live;
  logic        do_push;
  logic        full_a;
  logic        full_b;
  logic [15:0] gb_mid;
  logic [1:0]  fill_mid;
  logic [7:0]  fc_mid;
  logic [15:0] bl_mid;
  cmd_t        cmd;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;
  assign lim      = (max_frame_chars < MIN_BUDGET) ? MIN_BUDGET : max_frame_chars;
  assign crc_new  = crc_byte(packet_start ? 16'h0000 : crc_acc, data_byte);

  always_comb begin
    cmd              = '0;
    do_push          = 1'b0;
    live             = 1'b0;
    full_a           = 1'b0;
    full_b           = 1'b0;
    gb_mid           = group_bytes;
    fill_mid         = group_fill;
    fc_mid           = frame_chars;
    bl_mid           = bytes_left;
    crc_acc_next     = crc_acc;
    group_bytes_next = group_bytes;
    group_fill_next  = group_fill;
    frame_chars_next = frame_chars;
    bytes_left_next  = bytes_left;

    if (packet_start) begin
      // A new packet drops whatever was in progress.
      group_bytes_next = '0;
      group_fill_next  = '0;
      frame_chars_next = '0;
      bytes_left_next  = '0;
      if (packet_len != 16'd0) begin
        live                        = 1'b1;
        do_push                     = 1'b1;
        crc_acc_next                = crc_new;
        cmd.mask[POS_HDR_A +: 2]    = 2'b11;
        cmd.hdr_a_start             = 1'b1;
        cmd.mask[POS_GRP_A +: 4]    = 4'hF;
        cmd.grp_a                   = {packet_len, data_byte};
        gb_mid                      = '0;
        fill_mid                    = '0;
        fc_mid                      = 8'd6;
        bl_mid                      = packet_len - 16'd1;
      end
    end else if (bytes_left != 16'd0) begin
      live         = 1'b1;
      crc_acc_next = crc_new;
      bl_mid       = bytes_left - 16'd1;
      unique case (group_fill)
        2'd0: begin
          gb_mid   = {data_byte, 8'h00};
          fill_mid = 2'd1;
        end
        2'd1: begin
          gb_mid   = {group_bytes[15:8], data_byte};
          fill_mid = 2'd2;
        end
        default: begin
          // Third byte completes a data group; close the frame first if it is full.
          do_push = 1'b1;
          full_a  = ({1'b0, frame_chars} + 9'd4) >= {1'b0, lim};
          if (full_a) begin
            cmd.mask[POS_NL_A]       = 1'b1;
            cmd.mask[POS_HDR_A +: 2] = 2'b11;
          end
          cmd.mask[POS_GRP_A +: 4] = 4'hF;
          cmd.grp_a                = {group_bytes, data_byte};
          fc_mid                   = (full_a ? 8'd2 : frame_chars) + 8'd4;
          gb_mid                   = '0;
          fill_mid                 = '0;
        end
      endcase
    end

    if (live) begin
      if (bl_mid == 16'd0) begin
        // Last data byte: append the CRC tail and close the packet.
        do_push = 1'b1;
        full_b  = ({1'b0, fc_mid} + 9'd4) >= {1'b0, lim};
        if (full_b) begin
          cmd.mask[POS_NL_B]       = 1'b1;
          cmd.mask[POS_HDR_B +: 2] = 2'b11;
        end
        cmd.mask[POS_GRP_B +: 4] = 4'hF;
        unique case (fill_mid)
          2'd0: begin
            cmd.grp_b = {crc_new, 8'h00};
            cmd.b_pad = 1'b1;
          end
          2'd1: begin
            cmd.grp_b = {gb_mid[15:8], crc_new};
          end
          default: begin
            cmd.grp_b                = {gb_mid, crc_new[15:8]};
            cmd.grp_c                = crc_new[7:0];
            cmd.mask[POS_GRP_C +: 4] = 4'hF;
          end
        endcase
        cmd.mask[POS_NL_END] = 1'b1;
        group_bytes_next     = '0;
        group_fill_next      = '0;
        frame_chars_next     = '0;
        bytes_left_next      = '0;
      end else begin
        group_bytes_next = gb_mid;
        group_fill_next  = fill_mid;
        frame_chars_next = fc_mid;
        bytes_left_next  = bl_mid;
      end
    end
  end

  assign push     = accept && do_push;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc     <= '0;
      group_bytes <= '0;
      group_fill  <= '0;
      frame_chars <= '0;
      bytes_left  <= '0;
    end else if (accept) begin
      crc_acc     <= crc_acc_next;
      group_bytes <= group_bytes_next;
      group_fill  <= group_fill_next;
      frame_chars <= frame_chars_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/b64ft_back.sv */
// Back end: walks each queued command and sends one character per cycle while out_ready allows.
`default_nettype none
`include "base64_frame_transmitter_macros.svh"

module b64ft_back
  import b64ft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fifo_empty,
  output logic             pop,
  input  wire cmd_t        pop_cmd,
  input  wire logic [15:0] start_opcode,
  input  wire logic [15:0] cont_opcode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             run_last,
  output logic             packet_done
);

  cmd_t             cmd;
  pos_mask_t        rem;
  pos_mask_t        low;
  pos_mask_t        rem_after;
  logic             active;
  logic             fire;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] off;
  logic [15:0]      hdr_a;
  logic [7:0]       ch;

  assign active    = (rem != '0);
  assign low       = rem & (~rem + 1'b1);
  assign rem_after = rem & ~low;
  assign fire      = active && (!out_valid || out_ready);
  // The next command is taken while the last character of the current one goes out.
  assign pop       = !fifo_empty && (!active || (fire && (rem_after == '0)));
  assign hdr_a     = cmd.hdr_a_start ? start_opcode : cont_opcode;

  always_comb begin
    pos = '0;
    for (int i = 0; i < NUM_POS; i++) begin
      if (low[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    off = '0;
    ch  = CHAR_NL;
    priority if (pos == POS_W'(POS_NL_A) || pos == POS_W'(POS_NL_B) ||
                 pos == POS_W'(POS_NL_END)) begin
      ch = CHAR_NL;
    end else if (pos == POS_W'(POS_HDR_A)) begin
      ch = hdr_a[15:8];
    end else if (pos == POS_W'(POS_HDR_A + 1)) begin
      ch = hdr_a[7:0];
    end else if (pos == POS_W'(POS_HDR_B)) begin
      ch = cont_opcode[15:8];
    end else if (pos == POS_W'(POS_HDR_B + 1)) begin
      ch = cont_opcode[7:0];
    end else if (pos < POS_W'(POS_GRP_A + 4)) begin
      off = pos - POS_W'(POS_GRP_A);
      ch  = b64_char(sextet(cmd.grp_a, off[1:0]));
    end else if (pos < POS_W'(POS_GRP_B + 4)) begin
      off = pos - POS_W'(POS_GRP_B);
      ch  = (off[1:0] == 2'd3 && cmd.b_pad) ? CHAR_PAD
                                            : b64_char(sextet(cmd.grp_b, off[1:0]));
    end else begin
      // The lone CRC byte of a two-group tail: two characters and two pads.
      off = pos - POS_W'(POS_GRP_C);
      ch  = off[1] ? CHAR_PAD : b64_char(sextet({cmd.grp_c, 16'h0000}, off[1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        rem <= pop_cmd.mask;
      end else if (fire) begin
        rem <= rem_after;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_cmd;
    end
    if (fire) begin
      out_char    <= ch;
      run_last    <= (rem_after == '0);
      packet_done <= (pos == POS_W'(POS_NL_END));
    end
  end

  `B64FT_ASSERT_IMPLIES(a_done_is_last, clk, rst, out_valid && packet_done,
                        run_last && out_char == CHAR_NL)

endmodule

`default_nettype wire

/* hdl/base64_frame_transmitter.sv */
// An accepted item is written into the command queue, then loaded into the sequencer's mask register,
// and its first character leaves through the output register. The sequencer sends one character per
// cycle while out_ready allows; an item causes 0 to 12 characters.
// Input items are taken every cycle while the command queue (FIFO_DEPTH entries) has room.
// Reset (synchronous, rst high) clears packet state and the queue and restores register defaults.
`default_nettype none

module base64_frame_transmitter
  import b64ft_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = B64FT_FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  packet_start,
  input  wire logic [15:0]           packet_len,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_char,
  output logic                       run_last,
  output logic                       packet_done
);

  logic [15:0] start_opcode;
  logic [15:0] cont_opcode;
  logic [7:0]  max_frame_chars;
  logic        wr_en;
  reg_idx_t    reg_sel;

  logic push;
  logic pop;
  logic fifo_full;
  logic fifo_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_opcode    <= START_OPCODE_RST;
      cont_opcode     <= CONT_OPCODE_RST;
      max_frame_chars <= MAX_FRAME_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START_OPCODE: start_opcode    <= pwdata[15:0];
        REG_CONT_OPCODE:  cont_opcode     <= pwdata[15:0];
        REG_MAX_FRAME:    max_frame_chars <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START_OPCODE: prdata = {16'h0000, start_opcode};
      REG_CONT_OPCODE:  prdata = {16'h0000, cont_opcode};
      REG_MAX_FRAME:    prdata = {24'h000000, max_frame_chars};
      default:          prdata = '0;
    endcase
  end

  b64ft_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .packet_start    (packet_start),
    .packet_len      (packet_len),
    .max_frame_chars (max_frame_chars),
    .fifo_full       (fifo_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  b64ft_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  b64ft_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_empty   (fifo_empty),
    .pop          (pop),
    .pop_cmd      (pop_cmd),
    .start_opcode (start_opcode),
    .cont_opcode  (cont_opcode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .run_last     (run_last),
    .packet_done  (packet_done)
  );

endmodule

`default_nettype wire

/* test/tb_base64_frame_transmitter.sv */
// Testbench for the base64 frame transmitter: directed and random packets checked per character.
`default_nettype none

module tb_base64_frame_transmitter;
  import b64ft_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [0:63][7:0] B64_MAP =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } tx_char_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = '0;
  logic                  packet_start = 1'b0;
  logic [15:0]           packet_len = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_char;
  logic                  run_last;
  logic                  packet_done;

  // Register copies and packet state of the prediction.
  logic [15:0] cfg_start_op = START_OPCODE_RST;
  logic [15:0] cfg_cont_op = CONT_OPCODE_RST;
  logic [7:0]  cfg_budget = MAX_FRAME_RST;
  logic [15:0] pk_crc = '0;
  logic [15:0] pk_pend = '0;
  int          pk_pend_n = 0;
  logic [7:0]  pk_frame_len = '0;
  logic [15:0] pk_remain = '0;
  bit          pk_first = 1'b1;

  tx_char_t pending_chars[$];
  tx_char_t item_chars[$];
  tx_char_t want_char;

  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  int  rx_gap = 0;
  bit  steady = 1'b0;

  base64_frame_transmitter u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .packet_start(packet_start), .packet_len(packet_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char(out_char), .run_last(run_last), .packet_done(packet_done)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- prediction ----------------

  function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    bit          fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = c << 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void put_char(logic [7:0] c, bit done);
    item_chars.push_back('{c, 1'b0, done});
  endfunction

  function automatic void put_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int n);
    logic [23:0] w;
    w = {b0, (n >= 2) ? b1 : 8'h00, (n >= 3) ? b2 : 8'h00};
    put_char(B64_MAP[w[23:18]], 1'b0);
    put_char(B64_MAP[w[17:12]], 1'b0);
    put_char((n >= 2) ? B64_MAP[w[11:6]] : CHAR_PAD, 1'b0);
    put_char((n >= 3) ? B64_MAP[w[5:0]] : CHAR_PAD, 1'b0);
  endfunction

  function automatic void begin_frame();
    logic [15:0] op;
    op = pk_first ? cfg_start_op : cfg_cont_op;
    put_char(op[15:8], 1'b0);
    put_char(op[7:0], 1'b0);
    pk_frame_len = 8'd2;
    pk_first = 1'b0;
  endfunction

  // Budgets below the floor behave as the floor.
  function automatic void wrap_if_full();
    int lim;
    lim = (cfg_budget < MIN_BUDGET) ? int'(MIN_BUDGET) : int'(cfg_budget);
    if (int'(pk_frame_len) + 4 >= lim) begin
      put_char(CHAR_NL, 1'b0);
      begin_frame();
    end
  endfunction

  function automatic void drop_packet();
    pk_remain = '0;
    pk_pend_n = 0;
    pk_pend = '0;
    pk_frame_len = '0;
    pk_first = 1'b1;
  endfunction

  // The CRC tail joins the pending data bytes; a full frame pushes it into a new one.
  function automatic void close_packet();
    wrap_if_full();
    case (pk_pend_n)
      0: put_group(pk_crc[15:8], pk_crc[7:0], 8'h00, 2);
      1: put_group(pk_pend[15:8], pk_crc[15:8], pk_crc[7:0], 3);
      default: begin
        put_group(pk_pend[15:8], pk_pend[7:0], pk_crc[15:8], 3);
        put_group(pk_crc[7:0], 8'h00, 8'h00, 1);
      end
    endcase
    put_char(CHAR_NL, 1'b1);
    drop_packet();
  endfunction

  function automatic void predict_chars(logic [7:0] d, bit ps, logic [15:0] len);
    item_chars.delete();
    if (ps) begin
      drop_packet();
      if (len != 16'd0) begin
        pk_crc = '0;
        begin_frame();
        put_group(len[15:8], len[7:0], d, 3);
        pk_frame_len = pk_frame_len + 8'd4;
        pk_crc = crc_next(pk_crc, d);
        pk_remain = len - 16'd1;
        if (pk_remain == 16'd0) close_packet();
      end
    end else if (pk_remain != 16'd0) begin
      pk_crc = crc_next(pk_crc, d);
      pk_remain = pk_remain - 16'd1;
      case (pk_pend_n)
        0: begin
          pk_pend = {d, 8'h00};
          pk_pend_n = 1;
        end
        1: begin
          pk_pend[7:0] = d;
          pk_pend_n = 2;
        end
        default: begin
          wrap_if_full();
          put_group(pk_pend[15:8], pk_pend[7:0], d, 3);
          pk_frame_len = pk_frame_len + 8'd4;
          pk_pend_n = 0;
          pk_pend = '0;
        end
      endcase
      if (pk_remain == 16'd0) close_packet();
    end
    if (item_chars.size() > 0) item_chars[item_chars.size() - 1].last = 1'b1;
    foreach (item_chars[i]) pending_chars.push_back(item_chars[i]);
  endfunction

  // ---------------- drivers ----------------

  task automatic send_byte(logic [7:0] d, bit ps, logic [15:0] len);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    packet_start <= ps;
    packet_len <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_chars(d, ps, len);
  endtask

  task automatic send_packet(logic [15:0] len, int count);
    send_byte(8'($urandom_range(0, 255)), 1'b1, len);
    for (int i = 1; i < count; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
    end
  endtask

  // Stop offering items and wait until every predicted character has come out.
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_START_OPCODE: return {16'h0000, cfg_start_op};
      REG_CONT_OPCODE:  return {16'h0000, cfg_cont_op};
      default:          return {24'h000000, cfg_budget};
    endcase
  endfunction

  task automatic check_reg(reg_idx_t idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== reg_value(idx)) report_mismatch("register read", prdata, reg_value(idx));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_START_OPCODE: cfg_start_op = val[15:0];
      REG_CONT_OPCODE:  cfg_cont_op = val[15:0];
      default:          cfg_budget = val[7:0];
    endcase
    @(posedge clk);
    check_reg(idx);
  endtask

  task automatic set_config(logic [15:0] start_op, logic [15:0] cont_op, logic [7:0] budget);
    write_reg(REG_START_OPCODE, {16'h0000, start_op});
    write_reg(REG_CONT_OPCODE, {16'h0000, cont_op});
    write_reg(REG_MAX_FRAME, {24'h000000, budget});
  endtask

  // ---------------- output side ----------------

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      rx_gap = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected out_char", 32'(out_char), 32'd0);
      end else begin
        want_char = pending_chars.pop_front();
        if (out_char !== want_char.ch) begin
          report_mismatch("out_char", 32'(out_char), 32'(want_char.ch));
        end
        if (run_last !== want_char.last) begin
          report_mismatch("run_last", 32'(run_last), 32'(want_char.last));
        end
        if (packet_done !== want_char.done) begin
          report_mismatch("packet_done", 32'(packet_done), 32'(want_char.done));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------- tests ----------------

  task automatic test_reset_values();
    check_reg(REG_START_OPCODE);
    check_reg(REG_CONT_OPCODE);
    check_reg(REG_MAX_FRAME);
  endtask

  task automatic test_corner_items();
    send_byte(8'hA5, 1'b0, 16'd3);        // no packet open: ignored
    send_byte(8'hFF, 1'b1, 16'd0);        // zero length: nothing sent
    send_byte(8'hFF, 1'b1, 16'd1);
    send_byte(8'h00, 1'b1, 16'd1);
    send_byte(8'h00, 1'b1, 16'd2);
    send_byte(8'hFF, 1'b0, 16'hFFFF);
    send_packet(16'd3, 3);
    send_packet(16'd4, 4);
    // Longest length, then abandoned by a zero-length start.
    send_packet(16'hFFFF, 3);
    send_byte(8'h5A, 1'b1, 16'd0);
    // A restart in the middle of a packet drops it without a newline.
    send_packet(16'd5, 2);
    send_byte(8'h3C, 1'b1, 16'd1);
    drain_all();
  endtask

  // With the smallest budget, seven bytes fill the frame just as the data ends.
  task automatic test_exact_fill();
    set_config(16'hFFFF, 16'h0000, 8'd5);
    send_packet(16'd7, 7);
    drain_all();
  endtask

  task automatic test_random_traffic(int target);
    int sent;
    int r;
    int len;
    int cnt;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 20);
        send_packet(16'(len), len);
        sent += len;
      end else if (r < 88) begin
        // Truncated packet; whatever comes next continues or restarts it.
        len = $urandom_range(2, 65535);
        cnt = $urandom_range(1, 5);
        send_packet(16'(len), cnt);
        sent += cnt;
      end else if (r < 94) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b1, 16'd0);
      end
    end
    drain_all();
  endtask

  // The receiver stops for a long stretch while a packet streams in without gaps.
  task automatic test_backpressure();
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 8'd40);
    steady = 1'b1;
    hold_left = 300;
    send_packet(16'd30, 30);
    steady = 1'b0;
    drain_all();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_corner_items();
    test_exact_fill();
    test_random_traffic(20);
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 8'd255);
    test_random_traffic(15);
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               8'($urandom_range(17, 60)));
    steady = 1'b1;
    test_random_traffic(20);
    steady = 1'b0;
    test_backpressure();
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), MIN_BUDGET);
    test_random_traffic(15);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
